// ===== design/olid_pkg.sv =====
package olid_pkg;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TRAVERSE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_ENTRY     = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] item;
      logic               last;
   } rsp_type;

   // per-cell control, driven from the top level each cycle
   typedef struct packed {
      logic valid;   // cell holds a live entry
      logic tail;    // first free cell
      logic ins;     // insert transfer this cycle
      logic del;     // delete transfer this cycle
      logic rot;     // traverse step: rotate towards the head
      logic wrap;    // last live cell, takes the head value on rotate
   } cell_ctl_type;

endpackage

// ===== design/ordered_list_insert_delete_top.sv =====
// Channel   Ports                         Transfer
// request   start, busy, req_data         start high and busy low at the clock edge
// response  rsp_strobe, rsp_data          strobe high, carrying one result
//
// Insert, delete and the unused code leave busy low; insert and delete results appear
// in the cycle after the request is taken, and the unused code gives none.
// Traverse of a non-empty list holds busy while the cell row rotates each live entry
// through the head, and the next request is taken once busy falls again.
// Reset clears the occupancy count, the traverse flag and the strobe; cell contents
// are left as they are. The receiver cannot stall: results are never held.
module ordered_list_insert_delete_top
   import olid_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               trav_ff, trav_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [31:0] cell_value [CAPACITY];
   logic               found [CAPACITY+1];
   cell_ctl_type       cell_ctl [CAPACITY];

   logic               accept;
   logic               is_full, is_empty, found_any, cnt_last;
   logic               do_ins, do_del;
   op_type             op;

   assign accept    = start && !busy;
   assign op        = op_type'(req_data.operation);
   assign is_full   = (occ_ff >= CAP_OCC);
   assign is_empty  = (occ_ff == '0);
   assign found_any = found[CAPACITY];
   assign cnt_last  = (OCC_W'(cnt_ff) == (occ_ff - OCC_W'(1)));
   assign do_ins    = accept && (op == OP_INSERT) && !is_full;
   assign do_del    = accept && (op == OP_DELETE);

   assign found[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [OCC_W-1:0] POS = OCC_W'(i);
      localparam int NXT = (i + 1) % CAPACITY;

      always_comb begin
         cell_ctl[i].valid = (POS < occ_ff);
         cell_ctl[i].tail  = (POS == occ_ff);
         cell_ctl[i].ins   = do_ins;
         cell_ctl[i].del   = do_del;
         cell_ctl[i].rot   = trav_ff;
         cell_ctl[i].wrap  = (POS == (occ_ff - OCC_W'(1)));
      end

      olid_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .key        (req_data.value),
         .next_value (cell_value[NXT]),
         .head_value (cell_value[0]),
         .found_in   (found[i]),
         .value      (cell_value[i]),
         .found_out  (found[i+1])
      );
   end

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      if (trav_ff) begin
         rsp_strobe_in      = 1'b1;
         rsp_data_in.status = ST_ENTRY;
         rsp_data_in.item   = cell_value[0];
         rsp_data_in.last   = cnt_last;
      end else if (accept) begin
         rsp_data_in.item = req_data.value;
         rsp_data_in.last = 1'b1;
         unique case (op)
            OP_INSERT: begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = is_full ? ST_FULL : ST_INSERTED;
            end
            OP_DELETE: begin
               rsp_strobe_in = 1'b1;
               if (is_empty) begin
                  rsp_data_in.status = ST_EMPTY;
               end else begin
                  rsp_data_in.status = found_any ? ST_DELETED : ST_NOT_FOUND;
               end
            end
            OP_TRAVERSE: begin
               if (is_empty) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = ST_EMPTY;
                  rsp_data_in.item   = '0;
               end
            end
            default: begin
               rsp_strobe_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      occ_in  = occ_ff;
      trav_in = trav_ff;
      cnt_in  = cnt_ff;
      if (do_ins) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_del && found_any) begin
         occ_in = occ_ff - OCC_W'(1);
      end
      if (trav_ff) begin
         // advance one entry per cycle, drop out after the last
         if (cnt_last) begin
            trav_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + IDX_W'(1);
         end
      end else if (accept && (op == OP_TRAVERSE) && !is_empty) begin
         trav_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         trav_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         occ_ff        <= occ_in;
         trav_ff       <= trav_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = trav_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP_OCC)
      else $error("occupancy above capacity");

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> occ_ff != '0)
      else $error("traverse running on an empty list");

   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> rsp_strobe)
      else $error("traverse stream broken before its last entry");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> occ_ff == $past(occ_ff) + OCC_W'(1))
      else $error("insert did not advance occupancy");

endmodule

// ===== design/olid_cell.sv =====
module olid_cell
   import olid_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic signed [31:0] key,
   input  logic signed [31:0] next_value,
   input  logic signed [31:0] head_value,
   input  logic               found_in,
   output logic signed [31:0] value,
   output logic               found_out
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               hit;

   assign hit       = ctl.valid && (value_ff == key);
   assign found_out = found_in || hit;
   assign value     = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins && ctl.tail) begin
         value_in = key;
      end else if (ctl.del && found_out) begin
         // close the gap left by the first match
         value_in = next_value;
      end else if (ctl.rot) begin
         value_in = ctl.wrap ? head_value : next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== tb/olid_checker.sv =====
`timescale 1ns / 100ps

module olid_checker
   import olid_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending,
   output int      results_seen,
   output int      deepest
);

   logic signed [31:0] list_vals [$];
   rsp_type            due_results [$];
   int                 n_bad;
   int                 n_results;
   int                 depth_max;

   task automatic report_mismatch(input string what);
      $display("%0t olid_checker: mismatch: %s", $time, what);
      n_bad++;
   endtask

   // Mirror the list and queue up what this request should return.
   task automatic apply_list_op(input req_type rq);
      rsp_type r;
      int      hit;
      hit    = -1;
      r.item = rq.value;
      r.last = 1'b1;
      case (rq.operation)
         OP_INSERT: begin
            if (list_vals.size() >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_vals.push_back(rq.value);
               r.status = ST_INSERTED;
               if (list_vals.size() > depth_max) depth_max = list_vals.size();
            end
            due_results.push_back(r);
         end
         OP_DELETE: begin
            if (list_vals.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               foreach (list_vals[i])
                  if (hit < 0 && list_vals[i] == rq.value) hit = i;
               if (hit < 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  list_vals.delete(hit);
                  r.status = ST_DELETED;
               end
            end
            due_results.push_back(r);
         end
         OP_TRAVERSE: begin
            if (list_vals.size() == 0) begin
               r.status = ST_EMPTY;
               r.item   = '0;
               due_results.push_back(r);
            end else begin
               foreach (list_vals[i]) begin
                  r.status = ST_ENTRY;
                  r.item   = list_vals[i];
                  r.last   = (i == list_vals.size() - 1);
                  due_results.push_back(r);
               end
            end
         end
         default: ;  // unused code: no transfer out, list untouched
      endcase
   endtask

   task automatic match_result(input rsp_type got);
      rsp_type want;
      n_results++;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result status %0d item %0d last %0b",
                                   got.status, got.item, got.last));
         return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status,
                                   want.status));
      if (got.item !== want.item)
         report_mismatch($sformatf("item %0d, expected %0d", got.item, want.item));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_vals.delete();
         due_results.delete();
      end else begin
         // results of earlier requests first, then the request taken at this edge
         if (rsp_strobe) match_result(rsp_data);
         if (start && !busy) apply_list_op(req_data);
      end
      mismatches   <= n_bad;
      pending      <= due_results.size();
      results_seen <= n_results;
      deepest      <= depth_max;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import olid_pkg::*;

   localparam int                 CAPACITY   = 16;
   localparam int                 ITEM_TOTAL = 330;
   localparam int                 CALM_TAIL  = 40;
   localparam logic [1:0]         OP_UNUSED  = 2'd3;
   localparam logic signed [31:0] MOST_NEG   = 32'h8000_0000;
   localparam logic signed [31:0] MOST_POS   = 32'h7fff_ffff;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int mismatches;
   int pending;
   int results_seen;
   int deepest;
   int n_items;
   int n_ignored;

   logic signed [31:0] value_pool [8];

   ordered_list_insert_delete_top #(.CAPACITY(CAPACITY)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   olid_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen),
      .deepest      (deepest)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb_top: run limit reached, %0d results still due", pending);
      $display("tb: failure");
      $finish;
   end

   // Present one request and hold it until the transfer.
   task automatic send_request(input logic [1:0] op, input logic signed [31:0] val);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= {op, val};
      do @(posedge clock); while (busy);
      if (op == OP_UNUSED) n_ignored++;
      else n_items++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Hold off until every outstanding result has come back.
   task automatic drain_results;
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Mostly values from a small pool, so deletes find matches and duplicates occur.
   function automatic logic signed [31:0] pick_value;
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return $urandom_range(1) ? MOST_NEG : MOST_POS;
         default: return value_pool[$urandom_range(7)];
      endcase
   endfunction

   // lean 0 grows the list, 1 shrinks it, 2 keeps it roughly level
   function automatic logic [1:0] pick_op(input int lean);
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) return OP_UNUSED;
      if (roll < 15) return OP_TRAVERSE;
      case (lean)
         0:       return (roll < 75) ? OP_INSERT : OP_DELETE;
         1:       return (roll < 35) ? OP_INSERT : OP_DELETE;
         default: return (roll < 57) ? OP_INSERT : OP_DELETE;
      endcase
   endfunction

   initial begin
      logic [1:0] op;
      start     = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      n_items   = 0;
      n_ignored = 0;
      foreach (value_pool[i])
         value_pool[i] = (i < 4) ? $urandom : $urandom_range(6) - 3;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_request(OP_TRAVERSE, MOST_POS);   // traverse of an empty list
      send_request(OP_DELETE, MOST_NEG);     // delete from an empty list
      send_request(OP_UNUSED, 32'sd5);
      for (int i = 0; i < CAPACITY; i++)
         case (i)
            0:       send_request(OP_INSERT, MOST_NEG);
            1:       send_request(OP_INSERT, MOST_POS);
            2:       send_request(OP_INSERT, 32'sd0);
            3:       send_request(OP_INSERT, -32'sd1);
            4:       send_request(OP_INSERT, 32'h5555_5555);
            5:       send_request(OP_INSERT, 32'haaaa_aaaa);
            6:       send_request(OP_INSERT, -32'sd1);
            default: send_request(OP_INSERT, i * 1000 - 3);
         endcase
      send_request(OP_INSERT, 32'sd42);      // list full
      send_request(OP_TRAVERSE, 32'sd0);
      send_request(OP_DELETE, 32'sd12345);   // no match
      send_request(OP_DELETE, MOST_NEG);     // head
      send_request(OP_DELETE, -32'sd1);      // first of two equal entries
      send_request(OP_DELETE, (CAPACITY - 1) * 1000 - 3);   // tail
      send_request(OP_TRAVERSE, -32'sd1);
      drain_results();

      while (n_items < ITEM_TOTAL) begin
         op = pick_op((n_items / 30) % 3);
         send_request(op, pick_value());
         if (n_items < ITEM_TOTAL - CALM_TAIL) begin
            if ($urandom_range(3) == 0) idle_sender($urandom_range(15, 1));
            else if ($urandom_range(40) == 0) drain_results();
         end
      end

      drain_results();
      repeat (CAPACITY + 8) @(negedge clock);
      $display("tb_top: %0d list requests and %0d unused codes sent, %0d results checked",
               n_items, n_ignored, results_seen);
      $display("tb_top: list grew to %0d of %0d entries", deepest, CAPACITY);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== ordered_list_insert_delete_top.f =====
design/olid_pkg.sv
design/olid_cell.sv
design/ordered_list_insert_delete_top.sv
tb/olid_checker.sv
tb/tb_top.sv
